// ===== rtl/lphm_pkg.sv =====
package lphm_pkg;

  // field widths
  localparam int KEY_W = 16;
  localparam int VAL_W = 16;
  localparam int CMD_W = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

  // hash multiplier and product width (14-bit constant times 16-bit key)
  localparam int               PROD_W    = 30;
  localparam logic [13:0]      HASH_MULT = 14'd9649;

  // table entry: {used, key, value}
  localparam int ENTRY_W = 1 + KEY_W + VAL_W;

  // request queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } lphm_req_t;

endpackage

// ===== rtl/linear_probe_hash_map.sv =====
// flow: the front hashes the key (multiply, reciprocal quotient, remainder, correction), the
// request passes through the queue, the back checks up to TABLE_SLOTS slots with probe reads
// at one slot per cycle, then an update step posts the result
// the back works on one request at a time, through its probe loop and update step;
// hashing of later requests overlaps the probe through a four-entry queue
// reset: synchronous, active low; a clearing pass then empties every slot, and no request is taken during it
module linear_probe_hash_map
  import lphm_pkg::*;
#(
  parameter int TABLE_SLOTS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // key [15:0], value [31:16]
  input  logic [1:0]  in_tuser,   // cmd [1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // found_value [15:0]
  output logic [0:0]  out_tuser   // ok [0]
);

  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam int QD_W   = SLOT_W + $bits(lphm_req_t);

  lphm_req_t         in_req;
  lphm_req_t         f_req, b_req;
  logic [SLOT_W-1:0] f_hash, b_hash;
  logic              f_valid, f_ready;
  logic              b_valid, b_ready;
  logic              clr_busy;
  logic              ok;

  // unpack input request
  assign in_req.cmd   = in_tuser;
  assign in_req.key   = in_tdata[15:0];
  assign in_req.value = in_tdata[31:16];

  lphm_front #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .SLOT_W      (SLOT_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .hold      (clr_busy),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req_in    (in_req),
    .q_valid   (f_valid),
    .q_ready   (f_ready),
    .q_req     (f_req),
    .q_hash    (f_hash)
  );

  lphm_queue #(
    .DATA_W (QD_W)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  ({f_hash, f_req}),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_data  ({b_hash, b_req})
  );

  lphm_back #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .SLOT_W      (SLOT_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr_busy  (clr_busy),
    .q_valid   (b_valid),
    .q_ready   (b_ready),
    .q_req     (b_req),
    .q_hash    (b_hash),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_ok    (ok),
    .out_found (out_tdata)
  );

  assign out_tuser = ok;

endmodule

// ===== rtl/lphm_front.sv =====
module lphm_front
  import lphm_pkg::*;
#(
  parameter int TABLE_SLOTS = 1024,
  parameter int SLOT_W      = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              hold,
  input  logic              req_valid,
  output logic              req_ready,
  input  lphm_req_t         req_in,
  output logic              q_valid,
  input  logic              q_ready,
  output lphm_req_t         q_req,
  output logic [SLOT_W-1:0] q_hash
);

  localparam int REM_W  = SLOT_W + 1;
  localparam int FULL_W = 2 * PROD_W;

  // floor(2^PROD_W / TABLE_SLOTS); the estimated quotient is low by at most one
  localparam logic [PROD_W-1:0] RECIP   = PROD_W'((64'd1 << PROD_W) / 64'(TABLE_SLOTS));
  localparam logic [PROD_W-1:0] SLOTS_P = PROD_W'(TABLE_SLOTS);

  typedef enum logic [2:0] {F_IDLE, F_QUO, F_REM, F_FIX, F_PUSH} fstate_t;

  fstate_t                state_r, state_nxt;
  lphm_req_t              req_r, req_nxt;
  logic [PROD_W-1:0]      prod_r, prod_nxt;
  logic [PROD_W-1:0]      quo_r, quo_nxt;
  logic [REM_W-1:0]       rem_raw_r, rem_raw_nxt;
  logic [SLOT_W-1:0]      rem_r, rem_nxt;
  logic [FULL_W-1:0]      quo_full;
  logic [PROD_W-1:0]      diff;

  assign req_ready = (state_r == F_IDLE) && !hold;
  assign q_valid   = (state_r == F_PUSH);
  assign q_req     = req_r;
  assign q_hash    = rem_r;

  // start slot = product mod TABLE_SLOTS: reciprocal quotient, remainder, one correction
  assign quo_full = FULL_W'(prod_r) * FULL_W'(RECIP);
  assign diff     = prod_r - quo_r * SLOTS_P;

  always_comb begin
    state_nxt   = state_r;
    req_nxt     = req_r;
    prod_nxt    = prod_r;
    quo_nxt     = quo_r;
    rem_raw_nxt = rem_raw_r;
    rem_nxt     = rem_r;
    unique case (state_r)
      F_IDLE: begin
        if (req_valid && req_ready) begin
          req_nxt   = req_in;
          prod_nxt  = PROD_W'(HASH_MULT) * PROD_W'(req_in.key);
          state_nxt = F_QUO;
        end
      end
      F_QUO: begin
        quo_nxt   = quo_full[FULL_W-1:PROD_W];
        state_nxt = F_REM;
      end
      F_REM: begin
        // remainder is below twice the table size, so the low bits suffice
        rem_raw_nxt = diff[REM_W-1:0];
        state_nxt   = F_FIX;
      end
      F_FIX: begin
        if (rem_raw_r >= REM_W'(TABLE_SLOTS)) begin
          rem_nxt = SLOT_W'(rem_raw_r - REM_W'(TABLE_SLOTS));
        end else begin
          rem_nxt = SLOT_W'(rem_raw_r);
        end
        state_nxt = F_PUSH;
      end
      F_PUSH: begin
        if (q_ready) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  // state and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    req_r     <= req_nxt;
    prod_r    <= prod_nxt;
    quo_r     <= quo_nxt;
    rem_raw_r <= rem_raw_nxt;
    rem_r     <= rem_nxt;
  end

endmodule

// ===== rtl/lphm_queue.sv =====
module lphm_queue
  import lphm_pkg::*;
#(
  parameter int DATA_W = 44
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  logic [DATA_W-1:0] wr_data,
  output logic              rd_valid,
  input  logic              rd_ready,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0]  buf_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r;
  logic               push, pop;

  assign wr_ready = (cnt_r != Q_CNT_W'(Q_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = buf_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== rtl/lphm_back.sv =====
module lphm_back
  import lphm_pkg::*;
#(
  parameter int TABLE_SLOTS = 1024,
  parameter int SLOT_W      = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  output logic              clr_busy,
  input  logic              q_valid,
  output logic              q_ready,
  input  lphm_req_t         q_req,
  input  logic [SLOT_W-1:0] q_hash,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_ok,
  output logic [VAL_W-1:0]  out_found
);

  localparam int CNT_W = $clog2(TABLE_SLOTS + 1);

  typedef enum logic [1:0] {B_CLEAR, B_IDLE, B_PROBE, B_DONE} bstate_t;

  bstate_t             state_r, state_nxt;
  lphm_req_t           req_r, req_nxt;
  logic [SLOT_W-1:0]   clr_addr_r, clr_addr_nxt;
  logic [SLOT_W-1:0]   addr_r, addr_nxt;
  logic [CNT_W-1:0]    iss_cnt_r, iss_cnt_nxt;
  logic [CNT_W-1:0]    chk_cnt_r, chk_cnt_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic [SLOT_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic                hit_r, hit_nxt;
  logic [SLOT_W-1:0]   hit_idx_r, hit_idx_nxt;
  logic [VAL_W-1:0]    hit_val_r, hit_val_nxt;
  logic                emp_r, emp_nxt;
  logic [SLOT_W-1:0]   emp_idx_r, emp_idx_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_ok_r, out_ok_nxt;
  logic [VAL_W-1:0]    out_found_r, out_found_nxt;

  // slot memory
  logic [ENTRY_W-1:0]  mem [TABLE_SLOTS];
  logic [ENTRY_W-1:0]  rdata_r;
  logic [SLOT_W-1:0]   raddr;
  logic                we;
  logic [SLOT_W-1:0]   waddr;
  logic [ENTRY_W-1:0]  wdata;

  logic                ent_used;
  logic [KEY_W-1:0]    ent_key;
  logic [VAL_W-1:0]    ent_val;

  assign ent_used = rdata_r[ENTRY_W-1];
  assign ent_key  = rdata_r[VAL_W +: KEY_W];
  assign ent_val  = rdata_r[VAL_W-1:0];

  assign clr_busy  = (state_r == B_CLEAR);
  assign q_ready   = (state_r == B_IDLE);
  assign out_valid = out_valid_r;
  assign out_ok    = out_ok_r;
  assign out_found = out_found_r;

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    clr_addr_nxt  = clr_addr_r;
    addr_nxt      = addr_r;
    iss_cnt_nxt   = iss_cnt_r;
    chk_cnt_nxt   = chk_cnt_r;
    rd_vld_nxt    = 1'b0;
    rd_idx_nxt    = rd_idx_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    hit_val_nxt   = hit_val_r;
    emp_nxt       = emp_r;
    emp_idx_nxt   = emp_idx_r;
    out_valid_nxt = out_valid_r;
    out_ok_nxt    = out_ok_r;
    out_found_nxt = out_found_r;
    raddr         = addr_r;
    we            = 1'b0;
    waddr         = clr_addr_r;
    wdata         = '0;

    // result taken downstream
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      // sweep every slot to empty after reset
      B_CLEAR: begin
        we           = 1'b1;
        waddr        = clr_addr_r;
        wdata        = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == SLOT_W'(TABLE_SLOTS - 1)) begin
          state_nxt = B_IDLE;
        end
      end

      // take the next request from the queue
      B_IDLE: begin
        if (q_valid) begin
          req_nxt     = q_req;
          addr_nxt    = q_hash;
          iss_cnt_nxt = '0;
          chk_cnt_nxt = '0;
          hit_nxt     = 1'b0;
          emp_nxt     = 1'b0;
          if (q_req.cmd == CMD_INSERT || q_req.cmd == CMD_DELETE ||
              q_req.cmd == CMD_LOOKUP) begin
            state_nxt = B_PROBE;
          end else begin
            state_nxt = B_DONE;
          end
        end
      end

      // one read issued and one entry checked per cycle
      B_PROBE: begin
        if (iss_cnt_r != CNT_W'(TABLE_SLOTS)) begin
          raddr       = addr_r;
          rd_vld_nxt  = 1'b1;
          rd_idx_nxt  = addr_r;
          iss_cnt_nxt = iss_cnt_r + 1'b1;
          if (addr_r == SLOT_W'(TABLE_SLOTS - 1)) begin
            addr_nxt = '0;
          end else begin
            addr_nxt = addr_r + 1'b1;
          end
        end
        if (rd_vld_r) begin
          if (ent_used && ent_key == req_r.key) begin
            hit_nxt     = 1'b1;
            hit_idx_nxt = rd_idx_r;
            hit_val_nxt = ent_val;
            rd_vld_nxt  = 1'b0;
            state_nxt   = B_DONE;
          end else begin
            if (!ent_used && !emp_r) begin
              emp_nxt     = 1'b1;
              emp_idx_nxt = rd_idx_r;
            end
            chk_cnt_nxt = chk_cnt_r + 1'b1;
            if (chk_cnt_r == CNT_W'(TABLE_SLOTS - 1)) begin
              rd_vld_nxt = 1'b0;
              state_nxt  = B_DONE;
            end
          end
        end
      end

      // once the output is free, update the table for insert or delete and post the result
      B_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = 1'b0;
          out_found_nxt = '0;
          case (req_r.cmd)
            CMD_INSERT: begin
              if (hit_r) begin
                we         = 1'b1;
                waddr      = hit_idx_r;
                wdata      = {1'b1, req_r.key, req_r.value};
                out_ok_nxt = 1'b1;
              end else if (emp_r) begin
                we         = 1'b1;
                waddr      = emp_idx_r;
                wdata      = {1'b1, req_r.key, req_r.value};
                out_ok_nxt = 1'b1;
              end
            end
            CMD_DELETE: begin
              if (hit_r) begin
                we         = 1'b1;
                waddr      = hit_idx_r;
                wdata      = {1'b0, req_r.key, req_r.value};
                out_ok_nxt = 1'b1;
              end
            end
            CMD_LOOKUP: begin
              if (hit_r) begin
                out_ok_nxt    = 1'b1;
                out_found_nxt = hit_val_r;
              end
            end
            default: begin
              out_ok_nxt = 1'b0;
            end
          endcase
          state_nxt = B_IDLE;
        end
      end

      default: state_nxt = B_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLEAR;
      clr_addr_r  <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r       <= req_nxt;
    addr_r      <= addr_nxt;
    iss_cnt_r   <= iss_cnt_nxt;
    chk_cnt_r   <= chk_cnt_nxt;
    rd_idx_r    <= rd_idx_nxt;
    hit_r       <= hit_nxt;
    hit_idx_r   <= hit_idx_nxt;
    hit_val_r   <= hit_val_nxt;
    emp_r       <= emp_nxt;
    emp_idx_r   <= emp_idx_nxt;
    out_ok_r    <= out_ok_nxt;
    out_found_r <= out_found_nxt;
  end

  // slot memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

// ===== tb/tb_linear_probe_hash_map.sv =====
`timescale 1ns / 100ps

module tb_linear_probe_hash_map;
  import lphm_pkg::*;

  localparam int SLOTS       = 1024;
  localparam int RANDOM_REQS = 400;
  localparam int POOL_SIZE   = 32;
  localparam int CYCLE_LIMIT = 2000000;

  // code the block treats as a no-op
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic             ok;
    logic [VAL_W-1:0] found_value;
  } map_reply_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // key [15:0], value [31:16]
  logic [1:0]  in_tuser;   // cmd [1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // found_value [15:0]
  logic [0:0]  out_tuser;  // ok [0]

  // shadow copy of the slot table
  bit               shadow_used  [SLOTS];
  logic [KEY_W-1:0] shadow_key   [SLOTS];
  logic [VAL_W-1:0] shadow_value [SLOTS];

  map_reply_t expected_replies[$];
  int         mismatches;
  int         cycle_count;
  bit         gaps_on;

  linear_probe_hash_map #(.TABLE_SLOTS(SLOTS)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic int home_slot(input logic [KEY_W-1:0] key);
    return (int'(HASH_MULT) * int'(key)) % SLOTS;
  endfunction

  // walk every slot from the home slot, stop on a key match
  function automatic void probe_table(input logic [KEY_W-1:0] key, output bit hit,
                                      output int hit_slot, output bit has_free,
                                      output int free_slot);
    int idx;
    int n;
    hit       = 1'b0;
    has_free  = 1'b0;
    hit_slot  = 0;
    free_slot = 0;
    idx       = home_slot(key);
    for (n = 0; n < SLOTS && !hit; n++) begin
      if (shadow_used[idx]) begin
        if (shadow_key[idx] == key) begin
          hit      = 1'b1;
          hit_slot = idx;
        end
      end else if (!has_free) begin
        has_free  = 1'b1;
        free_slot = idx;
      end
      idx = (idx + 1) % SLOTS;
    end
  endfunction

  // apply one request to the shadow table and return the reply it should give
  function automatic map_reply_t apply_command(input logic [CMD_W-1:0] cmd,
                                               input logic [KEY_W-1:0] key,
                                               input logic [VAL_W-1:0] value);
    map_reply_t reply;
    bit         hit;
    bit         has_free;
    int         hit_slot;
    int         free_slot;
    reply = '0;
    probe_table(key, hit, hit_slot, has_free, free_slot);
    case (cmd)
      CMD_INSERT: begin
        if (hit) begin
          shadow_value[hit_slot] = value;
          reply.ok = 1'b1;
        end else if (has_free) begin
          shadow_used[free_slot]  = 1'b1;
          shadow_key[free_slot]   = key;
          shadow_value[free_slot] = value;
          reply.ok = 1'b1;
        end
      end
      CMD_DELETE: begin
        if (hit) begin
          shadow_used[hit_slot] = 1'b0;
          reply.ok = 1'b1;
        end
      end
      CMD_LOOKUP: begin
        if (hit) begin
          reply.ok          = 1'b1;
          reply.found_value = shadow_value[hit_slot];
        end
      end
      default: begin
      end
    endcase
    return reply;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (!gaps_on || roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
    mismatches++;
  endtask

  // one request; tvalid stays high on return so the next can follow directly
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                              input logic [VAL_W-1:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {value, key};
    in_tuser  <= cmd;
    do @(posedge clk); while (!in_tready);
    expected_replies.push_back(apply_command(cmd, key, value));
  endtask

  // hold off new requests until every reply is back
  task automatic drain_replies();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_replies.size() != 0);
  endtask

  // reply checker
  always @(posedge clk) begin : check_replies
    map_reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_replies.size() == 0) begin
        report_mismatch("unrequested reply", out_tdata, 0);
      end else begin
        want = expected_replies.pop_front();
        if (out_tuser[0] !== want.ok)
          report_mismatch("ok", out_tuser[0], want.ok);
        if (out_tdata !== want.found_value)
          report_mismatch("found_value", out_tdata, want.found_value);
      end
    end
  end

  // result side backpressure
  initial begin : drive_out_ready
    int stall_left;
    stall_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
      end else if (gaps_on && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
      end
      out_tready <= (stall_left == 0);
    end
  end

  // each command on an empty table, extreme keys and values, no-op code
  task automatic test_basic_commands();
    send_request(CMD_INSERT, 16'h0000, 16'h0000);
    send_request(CMD_INSERT, 16'hFFFF, 16'hFFFF);
    send_request(CMD_LOOKUP, 16'h0000, 16'hFFFF);
    send_request(CMD_LOOKUP, 16'hFFFF, 16'h0000);
    send_request(CMD_LOOKUP, 16'h1234, 16'h0000);
    send_request(CMD_DELETE, 16'h1234, 16'hFFFF);
    send_request(CMD_INSERT, 16'hFFFF, 16'hA5A5);
    send_request(CMD_LOOKUP, 16'hFFFF, 16'h5A5A);
    send_request(CMD_DELETE, 16'h0000, 16'h0000);
    send_request(CMD_LOOKUP, 16'h0000, 16'h0000);
    send_request(CMD_DELETE, 16'h0000, 16'h0000);
    send_request(CMD_UNUSED, 16'hFFFF, 16'hFFFF);
    send_request(CMD_LOOKUP, 16'hFFFF, 16'h0000);
  endtask

  // colliding keys around the last slot, a hole in the chain, slot reuse
  task automatic test_probe_wraparound();
    logic [KEY_W-1:0] wrap_key;
    int               k;
    wrap_key = '0;
    for (k = 0; k < SLOTS; k++) begin
      if (home_slot(KEY_W'(k)) == SLOTS - 1) wrap_key = KEY_W'(k);
    end
    send_request(CMD_INSERT, wrap_key, 16'h1111);
    send_request(CMD_INSERT, wrap_key + 16'd1024, 16'h2222);
    send_request(CMD_INSERT, wrap_key + 16'd2048, 16'h3333);
    send_request(CMD_LOOKUP, wrap_key + 16'd2048, 16'h0000);
    send_request(CMD_DELETE, wrap_key + 16'd1024, 16'h0000);
    send_request(CMD_LOOKUP, wrap_key + 16'd2048, 16'h0000);
    send_request(CMD_INSERT, wrap_key + 16'd3072, 16'h4444);
    send_request(CMD_LOOKUP, wrap_key + 16'd3072, 16'h0000);
    send_request(CMD_LOOKUP, wrap_key + 16'd1024, 16'h0000);
    send_request(CMD_INSERT, wrap_key + 16'd64512, 16'h8001);
    send_request(CMD_LOOKUP, wrap_key + 16'd64512, 16'h0000);
  endtask

  // mostly commands on a small key pool with collision families, some noise
  task automatic test_random_traffic();
    logic [KEY_W-1:0] key_pool [POOL_SIZE];
    logic [KEY_W-1:0] base_key;
    logic [CMD_W-1:0] cmd;
    int               i;
    int               roll;
    base_key = KEY_W'($urandom_range(0, 65535));
    for (i = 0; i < POOL_SIZE; i++) begin
      if (i < POOL_SIZE / 2) key_pool[i] = KEY_W'($urandom_range(0, 65535));
      else key_pool[i] = base_key + KEY_W'((i - POOL_SIZE / 2) * 1024);
    end
    for (i = 0; i < RANDOM_REQS; i++) begin
      if (i % 50 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      if (i % 100 == 99) drain_replies();
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        send_request(CMD_W'($urandom_range(0, 3)), KEY_W'($urandom_range(0, 65535)),
                     VAL_W'($urandom_range(0, 65535)));
      end else begin
        if (roll < 12) cmd = CMD_UNUSED;
        else if (roll < 50) cmd = CMD_INSERT;
        else if (roll < 68) cmd = CMD_DELETE;
        else cmd = CMD_LOOKUP;
        send_request(cmd, key_pool[$urandom_range(0, POOL_SIZE - 1)],
                     VAL_W'($urandom_range(0, 65535)));
      end
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    gaps_on    = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_basic_commands();
    test_probe_wraparound();
    test_random_traffic();

    // let any stray reply show up before the verdict
    drain_replies();
    repeat (SLOTS + 64) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/lphm_pkg.sv
rtl/lphm_front.sv
rtl/lphm_queue.sv
rtl/lphm_back.sv
rtl/linear_probe_hash_map.sv
tb/tb_linear_probe_hash_map.sv
